@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion, checked during reset as well
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/psf1_pkg.sv @@
// Types and constants for the PSF1 unicode table decoder
package psf1_pkg;

  localparam int unsigned GLYPH_STORE = 512;
  localparam int unsigned MAX_PAIRS   = 8192;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [10:0] GLYPH_LIM   = 11'(GLYPH_STORE);
  localparam logic [14:0] PAIR_LIM    = 15'(MAX_PAIRS);
  localparam logic [9:0]  COUNT_SAT   = 10'd1023;
  localparam logic [9:0]  GLYPHS_RST  = 10'd256;
  localparam logic [7:0]  BYTE_SEP    = 8'hFF;
  localparam logic [15:0] CELL_TERM   = 16'hFFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;

  typedef enum logic {
    REG_TABLE_FORMAT = 1'b0,
    REG_GLYPH_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FMT_B16  = 1'b0,
    FMT_UTF8 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        pair_valid;
    logic [15:0] code_point;
    logic [8:0]  glyph_index;
    logic        table_done;
    logic        table_ok;
    logic [13:0] pair_total;
  } out_t;

  // byte classes worked out ahead of the decoder
  typedef struct packed {
    logic is_sep;
    logic is_ascii;
    logic is_lead2;
    logic is_lead3;
    logic is_lead4;
    logic is_cont;
  } cls_t;

  typedef struct packed {
    in_t  item;
    cls_t cls;
  } q_entry_t;

endpackage

@@ hw/rtl/psf1_fifo.sv @@
// Small register queue with valid/stall handshake on both sides
module psf1_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         not_empty,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/psf1_front.sv @@
// Front end: takes table bytes, classifies them and queues them for the decoder
module psf1_front import psf1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  in_t      src_data,
  output logic     q_valid,
  input  logic     q_pop,
  output q_entry_t q_entry
);
  localparam int unsigned QW = $bits(q_entry_t);

  logic       q_full;
  logic       push;
  logic [7:0] b;
  q_entry_t   entry;
  logic [QW-1:0] pop_bits;

  assign b = src_data.table_byte;

  always_comb begin
    entry.item         = src_data;
    entry.cls.is_sep   = (b == BYTE_SEP);
    entry.cls.is_ascii = (b[7] == 1'b0);
    entry.cls.is_lead2 = (b[7:5] == 3'b110) && (b >= 8'hC2);
    entry.cls.is_lead3 = (b[7:4] == 4'b1110);
    entry.cls.is_lead4 = (b[7:3] == 5'b11110) && (b <= 8'hF4);
    entry.cls.is_cont  = (b[7:6] == 2'b10);
  end

  assign src_stall = q_full;
  assign push      = src_valid && !q_full;
  assign q_entry   = q_entry_t'(pop_bits);

  psf1_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (QW'(entry)),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .pop_data  (pop_bits)
  );

endmodule

@@ hw/rtl/psf1_back.sv @@
// Back end: table decode state, checks and result formation
module psf1_back import psf1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       q_valid,
  output logic       q_pop,
  input  q_entry_t   q_entry,
  input  logic       res_full,
  output logic       res_push,
  output out_t       res_item
);
  fmt_t        table_format;
  logic [9:0]  glyph_count;

  logic [7:0]  low_byte_hold;
  logic        odd_byte_phase;
  logic        pending_separator;
  logic [1:0]  bytes_still_needed;
  logic [20:0] code_accumulator;
  logic [9:0]  current_glyph;
  logic [9:0]  rows_seen;
  logic [13:0] pairs_emitted;
  logic        last_cell_terminator;
  logic        table_error;
  logic        terminator_seen;

  logic [7:0]  low_byte_hold_next;
  logic        odd_byte_phase_next;
  logic        pending_separator_next;
  logic [1:0]  bytes_still_needed_next;
  logic [20:0] code_accumulator_next;
  logic [9:0]  current_glyph_next;
  logic [9:0]  rows_seen_next;
  logic [13:0] pairs_emitted_next;
  logic        last_cell_terminator_next;
  logic        table_error_next;
  logic        terminator_seen_next;

  logic        cand;
  logic [15:0] offer_cp;
  logic [9:0]  offer_glyph;
  logic        offer_req;
  logic        table_good;
  logic        last;

  assign last     = q_entry.item.last_byte;
  assign q_pop    = q_valid && !res_full;
  assign res_push = q_pop && (cand || last);

  always_comb begin
    logic [7:0]  b;
    logic [15:0] cell_word;
    logic        u8_run;
    logic        fin;
    logic [9:0]  g_row;
    cls_t        c;

    b = q_entry.item.table_byte;
    c = q_entry.cls;
    cell_word = {b, low_byte_hold};
    u8_run = 1'b0;
    fin    = 1'b0;
    g_row  = current_glyph;

    low_byte_hold_next        = low_byte_hold;
    odd_byte_phase_next       = odd_byte_phase;
    pending_separator_next    = pending_separator;
    bytes_still_needed_next   = bytes_still_needed;
    code_accumulator_next     = code_accumulator;
    current_glyph_next        = current_glyph;
    rows_seen_next            = rows_seen;
    last_cell_terminator_next = last_cell_terminator;
    table_error_next          = table_error;
    terminator_seen_next      = terminator_seen;
    offer_req   = 1'b0;
    offer_cp    = '0;
    offer_glyph = current_glyph;
    table_good  = 1'b0;

    if (table_format == FMT_B16) begin
      if (!odd_byte_phase) begin
        low_byte_hold_next  = b;
        odd_byte_phase_next = 1'b1;
      end else begin
        odd_byte_phase_next = 1'b0;
        if (cell_word == CELL_TERM) begin
          last_cell_terminator_next = 1'b1;
          if (rows_seen < COUNT_SAT) begin
            rows_seen_next = rows_seen + 1'b1;
          end else begin
            table_error_next = 1'b1;
          end
          if (current_glyph < COUNT_SAT) begin
            current_glyph_next = current_glyph + 1'b1;
          end
        end else begin
          last_cell_terminator_next = 1'b0;
          if (cell_word != '0 && current_glyph < glyph_count) begin
            offer_req = 1'b1;
            offer_cp  = cell_word;
          end
        end
      end
      table_good = !odd_byte_phase_next && !table_error_next &&
                   (rows_seen_next == glyph_count) && last_cell_terminator_next;
    end else begin
      if (terminator_seen) begin
        table_error_next = 1'b1;
      end else if (pending_separator) begin
        pending_separator_next = 1'b0;
        if (c.is_sep) begin
          terminator_seen_next = 1'b1;
        end else begin
          if (rows_seen < COUNT_SAT) begin
            rows_seen_next = rows_seen + 1'b1;
          end
          if (current_glyph < COUNT_SAT) begin
            current_glyph_next = current_glyph + 1'b1;
          end
          g_row  = current_glyph_next;
          u8_run = 1'b1;
        end
      end else begin
        u8_run = 1'b1;
      end

      if (u8_run) begin
        if (bytes_still_needed != 2'd0) begin
          if (!c.is_cont) begin
            table_error_next        = 1'b1;
            bytes_still_needed_next = 2'd0;
          end else begin
            code_accumulator_next   = {code_accumulator[14:0], b[5:0]};
            bytes_still_needed_next = bytes_still_needed - 1'b1;
            fin = (bytes_still_needed == 2'd1);
          end
        end else begin
          priority if (c.is_sep) begin
            pending_separator_next = 1'b1;
          end else if (c.is_ascii) begin
            code_accumulator_next = {13'd0, b};
            fin = 1'b1;
          end else if (c.is_lead2) begin
            code_accumulator_next   = {16'd0, b[4:0]};
            bytes_still_needed_next = 2'd1;
          end else if (c.is_lead3) begin
            code_accumulator_next   = {17'd0, b[3:0]};
            bytes_still_needed_next = 2'd2;
          end else if (c.is_lead4) begin
            code_accumulator_next   = {18'd0, b[2:0]};
            bytes_still_needed_next = 2'd3;
          end else begin
            table_error_next = 1'b1;
          end
        end
        if (fin && code_accumulator_next <= BMP_MAX && {1'b0, g_row} < GLYPH_LIM) begin
          offer_req = 1'b1;
          offer_cp  = code_accumulator_next[15:0];
        end
      end
      offer_glyph = g_row;
      table_good  = terminator_seen_next && !table_error_next;
    end

    cand               = offer_req && !table_error && ({1'b0, pairs_emitted} < PAIR_LIM);
    pairs_emitted_next = cand ? pairs_emitted + 1'b1 : pairs_emitted;
  end

  always_comb begin
    res_item.pair_valid  = cand;
    res_item.code_point  = cand ? offer_cp : '0;
    res_item.glyph_index = cand ? offer_glyph[8:0] : '0;
    res_item.table_done  = last;
    res_item.table_ok    = last && table_good;
    res_item.pair_total  = pairs_emitted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_format <= FMT_B16;
      glyph_count  <= GLYPHS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TABLE_FORMAT: table_format <= fmt_t'(cfg_data[0]);
        REG_GLYPH_COUNT:  glyph_count  <= cfg_data;
        default:          glyph_count  <= glyph_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && last)) begin
      low_byte_hold        <= '0;
      odd_byte_phase       <= 1'b0;
      pending_separator    <= 1'b0;
      bytes_still_needed   <= '0;
      code_accumulator     <= '0;
      current_glyph        <= '0;
      rows_seen            <= '0;
      pairs_emitted        <= '0;
      last_cell_terminator <= 1'b0;
      table_error          <= 1'b0;
      terminator_seen      <= 1'b0;
    end else if (q_pop) begin
      low_byte_hold        <= low_byte_hold_next;
      odd_byte_phase       <= odd_byte_phase_next;
      pending_separator    <= pending_separator_next;
      bytes_still_needed   <= bytes_still_needed_next;
      code_accumulator     <= code_accumulator_next;
      current_glyph        <= current_glyph_next;
      rows_seen            <= rows_seen_next;
      pairs_emitted        <= pairs_emitted_next;
      last_cell_terminator <= last_cell_terminator_next;
      table_error          <= table_error_next;
      terminator_seen      <= terminator_seen_next;
    end
  end

endmodule

@@ hw/rtl/psf1_unicode_table_decoder.sv @@
// Top level of the PSF1 unicode table decoder
//
// Input channel src_*: one table byte per transfer, last_byte set on the final
// byte. Output channel res_*: one result per transfer, given for every byte
// that yields a (code point, glyph) pair and for the final byte, which also
// carries table_done and table_ok. If table_ok is 0 the pairs of that table
// are to be dropped.
// Config: cfg_we/cfg_index/cfg_data write table_format (0) or glyph_count (1);
// write only while no table is in flight.
// Throughput: one byte per cycle sustained while res_stall is low; the decode
// state updates once per byte and both queues are two entries deep.
// A byte passes the input queue, is decoded into the result queue and is
// offered on res_valid from there; a stall can hold it in either queue.
// When res_stall is high the result queue fills, the decoder holds, and the
// input queue then raises src_stall. Results are never lost or repeated.
// Reset empties both queues, clears the decode state and sets table_format
// to 16-bit cells and glyph_count to 256. Decode state also clears itself
// after the final byte of each table.
module psf1_unicode_table_decoder import psf1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       src_valid,
  output logic       src_stall,
  input  in_t        src_data,
  output logic       res_valid,
  input  logic       res_stall,
  output out_t       res_data
);
  localparam int unsigned OW = $bits(out_t);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;
  logic     res_full;
  logic     res_push;
  out_t     res_item;
  logic [OW-1:0] res_bits;
  logic     res_pop;

  psf1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry)
  );

  psf1_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  assign res_pop  = res_valid && !res_stall;
  assign res_data = out_t'(res_bits);

  psf1_fifo #(
    .W     (OW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (OW'(res_item)),
    .full      (res_full),
    .not_empty (res_valid),
    .pop       (res_pop),
    .pop_data  (res_bits)
  );

endmodule

@@ hw/rtl/psf1_checker.sv @@
// Port-level checks for the PSF1 unicode table decoder, with bind
`include "assert_macros.svh"

module psf1_checker import psf1_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input out_t res_data
);

  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res_data), "stalled result changed")
  `CHK_ASSERT(a_res_reason, clk, rst, res_valid |-> res_data.pair_valid || res_data.table_done, "result with neither pair nor end")
  `CHK_ASSERT(a_ok_with_done, clk, rst, res_valid && res_data.table_ok |-> res_data.table_done, "table_ok without table_done")
  `CHK_ASSERT(a_empty_pair, clk, rst, res_valid && !res_data.pair_valid |-> res_data.code_point == 16'd0 && res_data.glyph_index == 9'd0, "payload on a result without pair")
  `CHK_ASSERT(a_total_counts, clk, rst, res_valid && res_data.pair_valid |-> res_data.pair_total != 14'd0, "pair emitted with zero total")

endmodule

bind psf1_unicode_table_decoder psf1_checker u_psf1_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for the PSF1 unicode table decoder: byte stimulus, predictor, result checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psf1_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  logic       src_valid = 1'b0;
  logic       src_stall;
  in_t        src_data = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  out_t       res_data;

  psf1_unicode_table_decoder dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // decoder copy: registers and table state
  fmt_t        fmt_cfg = FMT_B16;
  logic [9:0]  glyphs_cfg = GLYPHS_RST;
  logic [7:0]  lo_hold;
  bit          odd_phase, sep_pending, term_cell, bad, ended;
  logic [1:0]  need;
  logic [20:0] acc;
  logic [9:0]  glyph, rows;
  int unsigned npairs;
  bit          pair_hit;
  logic [15:0] pair_cp;
  logic [9:0]  pair_glyph;

  out_t decoded_pairs[$];

  int err_count = 0;
  int results_seen = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic void clear_decode();
    lo_hold = '0; odd_phase = 0; sep_pending = 0; term_cell = 0; bad = 0; ended = 0;
    need = '0; acc = '0; glyph = '0; rows = '0; npairs = 0;
  endfunction

  initial clear_decode();

  function automatic void bump_row(input bit flag_over);
    if (rows < COUNT_SAT) rows++;
    else if (flag_over) bad = 1;
    if (glyph < COUNT_SAT) glyph++;
  endfunction

  function automatic void offer_pair(input logic [15:0] cp);
    if (bad) return;
    if (npairs < MAX_PAIRS) begin
      pair_hit = 1;
      pair_cp = cp;
      pair_glyph = glyph;
      npairs++;
    end
  endfunction

  function automatic void close_code();
    if (acc <= BMP_MAX && {1'b0, glyph} < GLYPH_LIM) offer_pair(acc[15:0]);
  endfunction

  function automatic void utf8_step(input logic [7:0] b);
    if (need != 0) begin
      if (b[7:6] != 2'b10) begin
        bad = 1;
        need = 0;
        return;
      end
      acc = {acc[14:0], b[5:0]};
      need--;
      if (need == 0) close_code();
      return;
    end
    if (b == BYTE_SEP) sep_pending = 1;
    else if (b < 8'h80) begin
      acc = 21'(b);
      close_code();
    end else if (b[7:5] == 3'b110 && b >= 8'hC2) begin
      acc = 21'(b[4:0]);
      need = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc = 21'(b[3:0]);
      need = 2'd2;
    end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
      acc = 21'(b[2:0]);
      need = 2'd3;
    end else bad = 1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    out_t        r;
    bit          ok;
    logic [15:0] cell16;
    pair_hit = 0; pair_cp = '0; pair_glyph = '0;
    if (fmt_cfg == FMT_B16) begin
      if (!odd_phase) begin
        lo_hold = b;
        odd_phase = 1;
      end else begin
        cell16 = {b, lo_hold};
        odd_phase = 0;
        if (cell16 == CELL_TERM) begin
          term_cell = 1;
          bump_row(1);
        end else begin
          term_cell = 0;
          if (cell16 != 0 && glyph < glyphs_cfg) offer_pair(cell16);
        end
      end
      ok = !odd_phase && !bad && rows == glyphs_cfg && term_cell;
    end else begin
      if (ended) bad = 1;
      else if (sep_pending) begin
        sep_pending = 0;
        if (b == BYTE_SEP) ended = 1;
        else begin
          bump_row(0);
          utf8_step(b);
        end
      end else utf8_step(b);
      ok = ended && !bad;
    end
    if (pair_hit || last) begin
      r.pair_valid  = pair_hit;
      r.code_point  = pair_hit ? pair_cp : '0;
      r.glyph_index = pair_hit ? pair_glyph[8:0] : '0;
      r.table_done  = last;
      r.table_ok    = last && ok;
      r.pair_total  = npairs[13:0];
      decoded_pairs.push_back(r);
    end
    if (last) clear_decode();
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (err_count < 40)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (decoded_pairs.size() == 0) flag_mismatch("result with none due", 16'(res_data), '0);
      else begin
        want = decoded_pairs.pop_front();
        if (res_data.pair_valid !== want.pair_valid)
          flag_mismatch("pair_valid", 16'(res_data.pair_valid), 16'(want.pair_valid));
        if (res_data.code_point !== want.code_point)
          flag_mismatch("code_point", res_data.code_point, want.code_point);
        if (res_data.glyph_index !== want.glyph_index)
          flag_mismatch("glyph_index", 16'(res_data.glyph_index), 16'(want.glyph_index));
        if (res_data.table_done !== want.table_done)
          flag_mismatch("table_done", 16'(res_data.table_done), 16'(want.table_done));
        if (res_data.table_ok !== want.table_ok)
          flag_mismatch("table_ok", 16'(res_data.table_ok), 16'(want.table_ok));
        if (res_data.pair_total !== want.pair_total)
          flag_mismatch("pair_total", 16'(res_data.pair_total), 16'(want.pair_total));
      end
      results_seen++;
    end
  end

  // receiver stalls; a requested hold keeps stall high for a long stretch
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= '{table_byte: b, last_byte: last};
    do @(posedge clk); while (src_stall);
    decode_byte(b, last);
  endtask

  task automatic send_table(input byte_q_t tbl);
    foreach (tbl[i]) send_byte(tbl[i], i == tbl.size() - 1);
  endtask

  // wait for every due result, then for the pipeline to empty
  task automatic settle();
    src_valid <= 1'b0;
    while (decoded_pairs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input fmt_t fmt, input logic [9:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TABLE_FORMAT;
    cfg_data  <= {9'($urandom_range(0, 511)), fmt};
    @(posedge clk);
    cfg_index <= REG_GLYPH_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_cfg = fmt;
    glyphs_cfg = count;
  endtask

  function automatic byte_q_t make_b16_table(input int n_rows, input int max_cells,
                                             input bit broken);
    byte_q_t     tbl;
    logic [15:0] c;
    for (int r = 0; r < n_rows; r++) begin
      repeat ($urandom_range(0, max_cells)) begin
        c = 16'($urandom);
        if ($urandom_range(0, 7) == 0) c = '0;
        if (c == CELL_TERM) c = 16'hFFFE;
        tbl.push_back(c[7:0]);
        tbl.push_back(c[15:8]);
      end
      tbl.push_back(BYTE_SEP);
      tbl.push_back(BYTE_SEP);
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0: if (tbl.size() >= 2) begin
          void'(tbl.pop_back());
          void'(tbl.pop_back());
        end
        1: tbl.push_back(8'($urandom));
        2: begin
          tbl.push_back(BYTE_SEP);
          tbl.push_back(BYTE_SEP);
        end
        default: if (tbl.size() > 0) tbl[$urandom_range(0, tbl.size() - 1)] = 8'($urandom);
      endcase
    end
    if (tbl.size() == 0) tbl.push_back(8'($urandom));
    return tbl;
  endfunction

  function automatic void push_sequence(ref byte_q_t tbl);
    int n_cont;
    case ($urandom_range(0, 3))
      0: begin
        tbl.push_back(8'($urandom_range(0, 8'h7F)));
        n_cont = 0;
      end
      1: begin
        tbl.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        n_cont = 1;
      end
      2: begin
        tbl.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        n_cont = 2;
      end
      default: begin
        tbl.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        n_cont = 3;
      end
    endcase
    repeat (n_cont) tbl.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endfunction

  function automatic byte_q_t make_utf8_table(input int n_rows, input int max_seq,
                                              input bit broken);
    byte_q_t    tbl;
    logic [7:0] junk;
    for (int r = 0; r < n_rows; r++) begin
      if (r > 0) tbl.push_back(BYTE_SEP);
      repeat ($urandom_range(r > 0 ? 1 : 0, max_seq)) push_sequence(tbl);
    end
    tbl.push_back(BYTE_SEP);
    tbl.push_back(BYTE_SEP);
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 3))
            0: junk = 8'hC0 + 8'($urandom_range(0, 1));
            1: junk = 8'($urandom_range(8'hF5, 8'hFE));
            2: junk = 8'($urandom_range(8'h80, 8'hBF));
            default: junk = 8'($urandom);
          endcase
          tbl.insert($urandom_range(0, tbl.size()), junk);
        end
        1: void'(tbl.pop_back());
        2: tbl.push_back(8'($urandom));
        default: tbl[$urandom_range(0, tbl.size() - 1)] = 8'($urandom);
      endcase
    end
    return tbl;
  endfunction

  task automatic test_reset_defaults();
    src_idle_pct = 0; stall_pct = 0;
    send_table(make_b16_table(256, 0, 0));
  endtask

  task automatic test_b16_cells();
    configure(FMT_B16, 10'd2);
    send_table('{8'h41, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF});
    // odd length
    send_table('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    // last cell not a terminator
    configure(FMT_B16, 10'd1);
    send_table('{8'h34, 8'h12});
    configure(FMT_B16, 10'd0);
    send_table('{8'h41, 8'h00, 8'hFF, 8'hFF});
  endtask

  task automatic test_utf8_sequences();
    configure(FMT_UTF8, 10'd512);
    send_table('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
                 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF, 8'h41, 8'hFF, 8'hFF});
  endtask

  task automatic test_utf8_errors();
    send_table('{8'h41, 8'hC0, 8'h42, 8'hFF, 8'hFF});
    send_table('{8'hE2, 8'h41, 8'hFF, 8'hFF});
    // bytes past the terminator
    send_table('{8'hFF, 8'hFF, 8'h41});
    send_table('{8'hF5, 8'hFF, 8'hFF});
    send_table('{8'h80, 8'hFF, 8'hFF});
  endtask

  task automatic test_random_tables();
    int idle_set[4]  = '{0, 78, 0, 28};
    int stall_set[4] = '{0, 0, 78, 28};
    int sent;
    int pick;
    byte_q_t tbl;
    fmt_t fmt;
    logic [9:0] count;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      src_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      while (sent < 30) begin
        fmt = fmt_t'($urandom_range(0, 1));
        if (fmt == FMT_B16) count = ($urandom_range(0, 9) == 0) ? 10'd1 : 10'($urandom_range(1, 6));
        else count = ($urandom_range(0, 4) == 0) ? 10'd512 : 10'($urandom_range(1, 512));
        configure(fmt, count);
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
          tbl.delete();
          repeat ($urandom_range(1, 16)) tbl.push_back(8'($urandom));
        end else if (fmt == FMT_B16) tbl = make_b16_table(count, 3, pick >= 7);
        else tbl = make_utf8_table($urandom_range(1, 5), 4, pick >= 7);
        send_table(tbl);
        sent += tbl.size();
      end
    end
  endtask

  task automatic test_input_backpressure();
    byte_q_t tbl;
    configure(FMT_UTF8, 10'd512);
    src_idle_pct = 0; stall_pct = 0;
    repeat (60) tbl.push_back(8'($urandom_range(0, 8'h7F)));
    tbl.push_back(BYTE_SEP);
    tbl.push_back(BYTE_SEP);
    hold_asked++;
    send_table(tbl);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_b16_cells();
    test_utf8_sequences();
    test_utf8_errors();
    test_random_tables();
    settle();
    src_idle_pct = 0; stall_pct = 0;
    test_input_backpressure();
    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/psf1_pkg.sv
hw/rtl/psf1_fifo.sv
hw/rtl/psf1_front.sv
hw/rtl/psf1_back.sv
hw/rtl/psf1_unicode_table_decoder.sv
hw/rtl/psf1_checker.sv
tb/tb_top.sv
